// File: hdl/dds_pkg.sv
// Shared types and constants for the differential-drive shaper with deadman stop.
// Used by diff_drive_shaper_deadman; no dependencies.
package dds_pkg;

    // Input word kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result word events
    localparam logic EV_DRIVE = 1'b0;
    localparam logic EV_STOP  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Reset values, Q3.12 where a speed
    localparam logic [14:0] DEADZONE_RST  = 15'd205;
    localparam logic [14:0] MIN_SPEED_RST = 15'd1434;
    localparam logic [14:0] MAX_SPEED_RST = 15'd4096;
    localparam logic [15:0] TIMEOUT_RST   = 16'd500;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_rate;
    } in_word_t;

    typedef struct packed {
        logic               event_res;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } out_word_t;

endpackage

// File: hdl/diff_drive_shaper_deadman.sv
// Differential-drive speed shaper with deadman stop, top level.
// One input register, one result register; depends on dds_pkg.
//
// Accepts one word per cycle and sustains one word per cycle while m_ready
// is high. A word is held in the input register, where mixing,
// shaping and the deadman countdown are evaluated, and its result is
// loaded into the result register when the word is processed, which raises
// m_valid. A command always yields a drive result; a tick
// yields a stop result only when the armed countdown expires, otherwise it
// is consumed without a result. When the result register is full and
// m_ready is low, s_ready drops once the input register also holds a word
// that yields a result.
// Configuration writes take effect at once and are meant for idle periods.
module diff_drive_shaper_deadman
    import dds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    logic [14:0] deadzone_reg;
    logic [14:0] min_speed_reg;
    logic [14:0] max_speed_reg;
    logic [15:0] timeout_reg;

    logic [15:0] countdown_reg, countdown_next;
    logic        armed_reg, armed_next;

    logic        in_valid_reg;
    in_word_t    in_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic        out_free;
    logic        emit;
    logic        proc;
    out_word_t   res;
    logic signed [17:0] left_sum, right_sum;

    function automatic logic [15:0] shape_speed(
        input logic signed [17:0] spd,
        input logic [14:0]        dz,
        input logic [14:0]        mn,
        input logic [14:0]        mx
    );
        logic        neg;
        logic [16:0] mag;
        logic [14:0] s;
        logic [15:0] r;
        neg = spd[17];
        mag = neg ? 17'(-spd) : spd[16:0];
        if (mag < {2'b00, dz}) begin
            r = '0;
        end else begin
            s = (mag > {2'b00, mx}) ? mx : mag[14:0];
            if (s < mn) begin
                s = mn;
            end
            r = neg ? (16'd0 - {1'b0, s}) : {1'b0, s};
        end
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg  <= DEADZONE_RST;
            min_speed_reg <= MIN_SPEED_RST;
            max_speed_reg <= MAX_SPEED_RST;
            timeout_reg   <= TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEADZONE:  deadzone_reg  <= cfg_wdata[14:0];
                REG_MIN_SPEED: min_speed_reg <= cfg_wdata[14:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_wdata[14:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign left_sum  = {{2{in_reg.linear_speed[15]}}, in_reg.linear_speed}
                     - {{2{in_reg.angular_rate[15]}}, in_reg.angular_rate};
    assign right_sum = {{2{in_reg.linear_speed[15]}}, in_reg.linear_speed}
                     + {{2{in_reg.angular_rate[15]}}, in_reg.angular_rate};

    // Evaluate the word held in the input register
    always_comb begin
        emit           = 1'b0;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        res.event_res  = EV_DRIVE;
        res.left_speed = shape_speed(left_sum, deadzone_reg, min_speed_reg,
                                     max_speed_reg);
        res.right_speed = shape_speed(right_sum, deadzone_reg, min_speed_reg,
                                      max_speed_reg);
        if (in_reg.kind == KIND_CMD) begin
            emit           = 1'b1;
            countdown_next = timeout_reg;
            armed_next     = 1'b1;
        end else if (armed_reg) begin
            if (countdown_reg <= 16'd1) begin
                // deadman expired: one stop word, then disarm
                emit            = 1'b1;
                countdown_next  = '0;
                armed_next      = 1'b0;
                res.event_res   = EV_STOP;
                res.left_speed  = '0;
                res.right_speed = '0;
            end else begin
                countdown_next = countdown_reg - 16'd1;
            end
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    // a tick that yields nothing leaves even when the result register is stuck
    assign proc     = in_valid_reg && (out_free || !emit);
    assign s_ready  = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc) begin
                countdown_reg <= countdown_next;
                armed_reg     <= armed_next;
            end
            if (proc && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (proc && emit) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Assertions
    a_disarmed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !armed_reg |-> countdown_reg == 16'd0)
        else $error("countdown nonzero while disarmed");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.event_res == EV_STOP) |->
        (out_reg.left_speed == 16'sd0 && out_reg.right_speed == 16'sd0))
        else $error("stop word with nonzero speeds");

    a_cmd_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_reg.kind == KIND_CMD) |=>
        (armed_reg && out_valid_reg && out_reg.event_res == EV_DRIVE))
        else $error("command did not arm or drive");

    a_stop_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && emit && in_reg.kind == KIND_TICK) |=>
        (!armed_reg && out_valid_reg && out_reg.event_res == EV_STOP))
        else $error("expiry did not disarm with stop word");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && !(proc && emit)) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

// File: bench/tb_diff_drive_shaper_deadman.sv
`timescale 1ns / 1ps
// Testbench for diff_drive_shaper_deadman: directed and random command/tick words with
// random stalls on both channels, checked against a scoreboard with its own shaper and timer.
// Depends on dds_pkg and the diff_drive_shaper_deadman RTL only.
module tb_diff_drive_shaper_deadman;
    import dds_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int MAX_TICK_RUN   = 40;

    class drive_checker;
        logic [14:0] deadzone;
        logic [14:0] min_speed;
        logic [14:0] max_speed;
        logic [15:0] timeout_ticks;
        logic [15:0] countdown;
        logic        armed;
        out_word_t   pending_drives[$];
        int          mismatches;
        int          busy_words;    // words that did more than get dropped

        function new();
            deadzone      = DEADZONE_RST;
            min_speed     = MIN_SPEED_RST;
            max_speed     = MAX_SPEED_RST;
            timeout_ticks = TIMEOUT_RST;
            countdown     = '0;
            armed         = 1'b0;
            mismatches    = 0;
            busy_words    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEADZONE:  deadzone = data[14:0];
                REG_MIN_SPEED: min_speed = data[14:0];
                REG_MAX_SPEED: max_speed = data[14:0];
                REG_TIMEOUT:   timeout_ticks = data;
                default: ;
            endcase
        endfunction

        // mixed speed is 17 bits, so the magnitude can reach 65536
        function logic [15:0] shape_wheel(logic signed [16:0] spd);
            logic [16:0] mag;
            logic [16:0] lim;
            mag = spd[16] ? 17'(-spd) : 17'(spd);
            if (mag < {2'b00, deadzone})
                return '0;
            lim = mag;
            if (lim > {2'b00, max_speed})
                lim = {2'b00, max_speed};
            if (lim < {2'b00, min_speed})
                lim = {2'b00, min_speed};
            return spd[16] ? -lim[15:0] : lim[15:0];
        endfunction

        function void absorb_word(in_word_t w);
            logic signed [16:0] lin;
            logic signed [16:0] ang;
            out_word_t r;
            lin = $signed(w.linear_speed);
            ang = $signed(w.angular_rate);
            if (w.kind == KIND_CMD) begin
                r.event_res   = EV_DRIVE;
                r.left_speed  = shape_wheel(lin - ang);
                r.right_speed = shape_wheel(lin + ang);
                pending_drives.push_back(r);
                countdown = timeout_ticks;
                armed = 1'b1;
                busy_words++;
            end else if (armed) begin
                busy_words++;
                // zero timeout behaves like one
                if (countdown <= 16'd1) begin
                    countdown     = '0;
                    armed         = 1'b0;
                    r.event_res   = EV_STOP;
                    r.left_speed  = '0;
                    r.right_speed = '0;
                    pending_drives.push_back(r);
                end else begin
                    countdown = countdown - 16'd1;
                end
            end
        endfunction

        function void note_miss(string field, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_drive(out_word_t got);
            out_word_t want;
            if (pending_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: event %0d left %0d right %0d",
                             got.event_res, $signed(got.left_speed), $signed(got.right_speed));
                return;
            end
            want = pending_drives.pop_front();
            if (got.event_res !== want.event_res)
                note_miss("event_res", want.event_res, got.event_res);
            if (got.left_speed !== want.left_speed)
                note_miss("left_speed", $signed(want.left_speed), $signed(got.left_speed));
            if (got.right_speed !== want.right_speed)
                note_miss("right_speed", $signed(want.right_speed), $signed(got.right_speed));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;

    drive_checker board;
    int idle_pct = 0;
    int stall_cnt = 0;
    int quiet_cycles = 0;

    diff_drive_shaper_deadman i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side backpressure in bursts of random length
    always @(posedge aclk) begin
        if (stall_cnt > 0) begin
            stall_cnt = stall_cnt - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
            stall_cnt = $urandom_range(16, 0);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // handshakes sampled mid-cycle, where everything driven at the edge has settled
    always @(negedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready)
                board.absorb_word(s_data);
            if (m_valid && m_ready)
                board.check_drive(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_diff_drive_shaper_deadman failed");
                    $finish;
                end
            end
        end
    end

    function automatic in_word_t cmd_word(logic [15:0] lin, logic [15:0] ang);
        in_word_t w;
        w.kind         = KIND_CMD;
        w.linear_speed = lin;
        w.angular_rate = ang;
        return w;
    endfunction

    // speed fields are don't-care on a tick, so fill them with noise
    function automatic in_word_t tick_word();
        in_word_t w;
        w.kind         = KIND_TICK;
        w.linear_speed = 16'($urandom);
        w.angular_rate = 16'($urandom);
        return w;
    endfunction

    function automatic logic [15:0] pick_speed();
        logic [15:0] v;
        case ($urandom_range(5, 0))
            0, 1: v = 16'($urandom);
            2: v = 16'($urandom_range(3000, 0));
            3: begin
                case ($urandom_range(2, 0))
                    0: v = {1'b0, board.deadzone};
                    1: v = {1'b0, board.min_speed};
                    default: v = {1'b0, board.max_speed};
                endcase
                v = v + 16'($urandom_range(4, 0)) - 16'd2;
            end
            4: begin
                case ($urandom_range(3, 0))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default: v = {1'b0, board.max_speed} + 16'($urandom_range(6000, 0));
        endcase
        if ($urandom_range(1, 0))
            v = -v;
        return v;
    endfunction

    // called on a clock edge; returns on the edge where the word is taken
    task automatic offer_word(input in_word_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        board.set_reg(idx, data);
    endtask

    task automatic apply_config(input logic [15:0] dz, input logic [15:0] mn,
                                input logic [15:0] mx, input logic [15:0] tmo);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_MIN_SPEED, mn);
        write_reg(REG_MAX_SPEED, mx);
        write_reg(REG_TIMEOUT, tmo);
        cfg_we <= 1'b0;
    endtask

    // ticks can leave no result, so wait out the pipeline after the last one
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending_drives.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int target);
        int stop_at;
        int span;
        int run_len;
        stop_at = board.busy_words + target;
        while (board.busy_words < stop_at) begin
            case ($urandom_range(9, 0))
                7: offer_word(cmd_word(pick_speed(), pick_speed()));
                8, 9: repeat ($urandom_range(3, 1)) offer_word(tick_word());
                default: begin
                    // command, then a tick run that lands around the deadman expiry
                    if ($urandom_range(3, 0) == 0)
                        offer_word(cmd_word(pick_speed(), 16'h0000));
                    else
                        offer_word(cmd_word(pick_speed(), pick_speed()));
                    span = (board.timeout_ticks == 16'd0) ? 1 : int'(board.timeout_ticks);
                    case ($urandom_range(3, 0))
                        0: run_len = span - 1;
                        1: run_len = span;
                        2: run_len = span + 1;
                        default: run_len = $urandom_range(span + 2, 0);
                    endcase
                    if (run_len > MAX_TICK_RUN)
                        run_len = $urandom_range(MAX_TICK_RUN, 0);
                    repeat (run_len) offer_word(tick_word());
                end
            endcase
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_DEADZONE;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        board     = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: deadzone, clamp, raise, full-scale sums
        idle_pct = 20;
        offer_word(tick_word());                        // not armed yet
        offer_word(cmd_word(16'h0000, 16'h0000));
        offer_word(cmd_word(16'h7FFF, 16'h7FFF));
        offer_word(cmd_word(16'h8000, 16'h8000));       // right sum is -65536
        offer_word(cmd_word(16'h8000, 16'h7FFF));
        offer_word(cmd_word(16'h7FFF, 16'h8000));
        offer_word(cmd_word(16'sd100, -16'sd100));
        offer_word(cmd_word(16'sd205, 16'sd0));
        offer_word(cmd_word(16'sd204, 16'sd0));
        offer_word(cmd_word(16'sd3000, 16'sd1000));
        offer_word(cmd_word(16'sd4096, 16'sd1));
        offer_word(tick_word());
        random_phase(150);

        settle();
        apply_config(16'd0, 16'd0, 16'h7FFF, 16'd1);
        offer_word(cmd_word(16'h0000, 16'h0000));
        offer_word(tick_word());
        offer_word(tick_word());
        offer_word(cmd_word(16'h8000, 16'h8000));
        random_phase(150);

        // zero timeout; zero speed with no deadzone gets raised
        settle();
        idle_pct = 0;
        apply_config(16'd0, 16'd1434, 16'd4096, 16'd0);
        offer_word(cmd_word(16'h0000, 16'h0000));
        offer_word(tick_word());
        random_phase(150);

        settle();
        idle_pct = 40;
        apply_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd3);
        random_phase(120);

        // min above max
        settle();
        idle_pct = 10;
        apply_config(16'd100, 16'd6000, 16'd2000, 16'd5);
        offer_word(cmd_word(16'sd3000, 16'sd0));
        offer_word(cmd_word(-16'sd3000, 16'sd0));
        random_phase(150);

        // top data bit lands outside the speed registers
        settle();
        idle_pct = 30;
        apply_config(16'hFFFF, 16'h8000, 16'h9000, 16'hFFFF);
        random_phase(100);

        repeat (4) begin
            settle();
            idle_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5);
            apply_config({1'($urandom), 15'($urandom_range(3000, 0))},
                         {1'($urandom), 15'($urandom_range(8000, 0))},
                         {1'($urandom), 15'($urandom_range(32767, 0))},
                         16'($urandom_range(12, 0)));
            random_phase(150);
        end

        // back to back, no stalls either side
        settle();
        idle_pct = 0;
        apply_config(16'd205, 16'd1434, 16'd4096, 16'($urandom_range(8, 1)));
        random_phase(150);

        settle();
        if (board.mismatches == 0 && board.pending_drives.size() == 0) begin
            $display("tb_diff_drive_shaper_deadman passed");
        end else begin
            $display("tb_diff_drive_shaper_deadman failed");
        end
        $finish;
    end

endmodule
